/* design/assert_macros.svh */
// Assertion macros shared by the light switch control RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is high.
`define DLSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// Clocked check that also holds during reset.
`define DLSC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define DLSC_ASSERT(lbl, clk, rst, prop)
`define DLSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* design/dlsc_pkg.sv */
// Shared types and constants for the debounced light switch control unit.
// No dependencies.
package dlsc_pkg;

   localparam int TIMER_WIDTH = 9;      // elapsed counter width, 9..32
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
   localparam logic [1:0] FLIP_LIMIT     = 2'd2;
   localparam logic [1:0] FLIP_MAX       = 2'd3;

   // event codes
   localparam logic [1:0] EV_TICK     = 2'd0;
   localparam logic [1:0] EV_SET_MODE = 2'd1;
   localparam logic [1:0] EV_ENABLE   = 2'd2;
   localparam logic [1:0] EV_DISABLE  = 2'd3;

   // light modes
   localparam logic [1:0] LM_AUTO    = 2'd0;
   localparam logic [1:0] LM_ON      = 2'd1;
   localparam logic [1:0] LM_OFF     = 2'd2;
   localparam logic [1:0] LM_INVALID = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_TIME  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELAY_ON_LEVEL = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic       switch_level;
      logic [1:0] new_light_mode;
   } item_type;

   typedef struct packed {
      logic       relay_pin;
      logic       notify;
      logic       rejected;
      logic [1:0] light_mode_now;
      logic       module_enabled;
      logic       state_changed;
   } result_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

endpackage

/* design/debounced_light_switch_control_unit.sv */
// Top level of the debounced light switch control unit: input and result registers.
// Depends on dlsc_pkg, dlsc_core and assert_macros.svh.
//
//   channel | dir | ports                        | beat contents
//   --------+-----+------------------------------+---------------------------------
//   req     | in  | req_tvalid/tready/tdata[7:0] | one event (tick, mode, en/dis)
//   rsp     | out | rsp_tvalid/tready/tdata[7:0] | one status result per event
//   csr     | in  | csr_we/addr/wdata[7:0]       | 0 debounce_time, 1 relay_on_level
//
// One beat per cycle sustained while rsp_tready is high; each request yields one
// response, via the input register, then update logic into the result register.
// The whole pipe stalls together when the response is held by rsp_tready low;
// req_tready is high whenever the result register is empty or being drained.
// Synchronous active-high reset enables the module, clears other state, sets debounce_time
// to 20 and relay_on_level to 1. Config writes take effect the next cycle.
`include "assert_macros.svh"
module debounced_light_switch_control_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] mode, [2] switch_level, [4:3] new_light_mode, [7:5] zero
   input  logic [7:0]                      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] relay_pin, [1] notify, [2] rejected, [4:3] light_mode_now,
   // [5] module_enabled, [6] state_changed, [7] zero
   output logic [7:0]                      rsp_tdata,
   input  logic                            csr_we,
   input  logic [dlsc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [dlsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dlsc_pkg::*;

   logic          advance;       // pipe moves this cycle
   logic          in_valid_ff;
   item_type      item_ff;
   logic          rsp_valid_ff;
   result_type    rsp_ff;
   result_type    core_result;
   csr_write_type csr;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign csr.we   = csr_we;
   assign csr.addr = csr_addr;
   assign csr.data = csr_wdata;

   // input register
   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (advance)
         in_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         item_ff.mode           <= req_tdata[1:0];
         item_ff.switch_level   <= req_tdata[2];
         item_ff.new_light_mode <= req_tdata[4:3];
      end
   end

   dlsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (in_valid_ff && advance),
      .item   (item_ff),
      .result (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff)
         rsp_ff <= core_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.state_changed, rsp_ff.module_enabled,
                        rsp_ff.light_mode_now, rsp_ff.rejected, rsp_ff.notify,
                        rsp_ff.relay_pin};

   // a stalled result stays put until taken
   `DLSC_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
   // no item is taken while the result register is full and stalled
   `DLSC_ASSERT_ALWAYS(a_no_take_stalled, clock,
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
   // an accepted beat shows up in the input register next cycle
   `DLSC_ASSERT(a_in_follow, clock, reset, (req_tvalid && req_tready) |=> in_valid_ff)

endmodule

/* design/dlsc_core.sv */
// Control state, config registers and per-beat update logic.
// Depends on dlsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dlsc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  dlsc_pkg::csr_write_type csr,
   input  logic                   fire,      // execute item this cycle
   input  dlsc_pkg::item_type     item,
   output dlsc_pkg::result_type   result
);
   import dlsc_pkg::*;

   localparam logic [TIMER_WIDTH-1:0] ELAPSED_MAX = '1;

   logic [7:0]             debounce_time_ff;
   logic                   relay_on_level_ff;

   logic                   enabled_ff,  enabled_in;
   logic [1:0]             light_mode_ff, light_mode_in;
   logic                   relay_on_ff, relay_on_in;
   logic                   recorded_ff, recorded_in;
   logic                   last_switch_ff, last_switch_in;
   logic                   armed_ff, armed_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [1:0]             flip_ff, flip_in;
   logic                   notify, rejected, changed;

   always_comb begin
      enabled_in     = enabled_ff;
      light_mode_in  = light_mode_ff;
      relay_on_in    = relay_on_ff;
      recorded_in    = recorded_ff;
      last_switch_in = last_switch_ff;
      armed_in       = armed_ff;
      elapsed_in     = elapsed_ff;
      flip_in        = flip_ff;
      notify         = 1'b0;
      rejected       = 1'b0;
      changed        = 1'b0;
      case (item.mode)
         EV_TICK: begin
            if (armed_ff && elapsed_ff != ELAPSED_MAX)
               elapsed_in = elapsed_ff + 1'b1;
            if (enabled_ff) begin
               if (flip_ff >= FLIP_LIMIT) begin
                  // two flips in a forced mode: back to auto
                  light_mode_in = LM_AUTO;
                  recorded_in   = relay_on_ff;
                  if (item.switch_level != relay_on_ff)
                     last_switch_in = ~item.switch_level;
                  changed = 1'b1;
                  flip_in = 2'd0;
               end else if (light_mode_ff == LM_ON && !recorded_ff) begin
                  relay_on_in = 1'b1;
                  recorded_in = 1'b1;
               end else if (light_mode_ff == LM_OFF && recorded_ff) begin
                  relay_on_in = 1'b0;
                  recorded_in = 1'b0;
               end
               if (last_switch_in != item.switch_level) begin
                  armed_in       = 1'b1;
                  elapsed_in     = '0;
                  last_switch_in = item.switch_level;
               end
               if (armed_in &&
                   elapsed_in > {{(TIMER_WIDTH-8){1'b0}}, debounce_time_ff}) begin
                  armed_in = 1'b0;
                  if (item.switch_level != recorded_in) begin
                     if (light_mode_in != LM_AUTO) begin
                        if (flip_in != FLIP_MAX)
                           flip_in = flip_in + 2'd1;
                     end else begin
                        relay_on_in = item.switch_level;
                        recorded_in = item.switch_level;
                        notify      = 1'b1;
                        changed     = 1'b1;
                        flip_in     = 2'd0;
                     end
                  end
               end
            end
         end
         EV_SET_MODE: begin
            if (item.new_light_mode == LM_INVALID) begin
               rejected = 1'b1;
            end else if (item.new_light_mode != light_mode_ff) begin
               light_mode_in = item.new_light_mode;
               recorded_in   = relay_on_ff;
               if (item.new_light_mode == LM_AUTO &&
                   item.switch_level != relay_on_ff)
                  last_switch_in = ~item.switch_level;
               changed = 1'b1;
            end
         end
         EV_ENABLE: begin
            if (!enabled_ff) begin
               if (light_mode_ff == LM_AUTO)
                  relay_on_in = item.switch_level;
               else
                  relay_on_in = (light_mode_ff == LM_ON);
               enabled_in = 1'b1;
               changed    = 1'b1;
            end
         end
         default: begin
            if (enabled_ff) begin
               relay_on_in = 1'b0;
               enabled_in  = 1'b0;
               changed     = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      result.relay_pin      = ~(relay_on_in ^ relay_on_level_ff);
      result.notify         = notify;
      result.rejected       = rejected;
      result.light_mode_now = light_mode_in;
      result.module_enabled = enabled_in;
      result.state_changed  = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff  <= DEBOUNCE_RESET;
         relay_on_level_ff <= 1'b1;
      end else if (csr.we) begin
         case (csr.addr)
            CSR_DEBOUNCE_TIME:  debounce_time_ff  <= csr.data;
            CSR_RELAY_ON_LEVEL: relay_on_level_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b1;
         light_mode_ff  <= LM_AUTO;
         relay_on_ff    <= 1'b0;
         recorded_ff    <= 1'b0;
         last_switch_ff <= 1'b0;
         armed_ff       <= 1'b0;
         elapsed_ff     <= '0;
         flip_ff        <= 2'd0;
      end else if (fire) begin
         enabled_ff     <= enabled_in;
         light_mode_ff  <= light_mode_in;
         relay_on_ff    <= relay_on_in;
         recorded_ff    <= recorded_in;
         last_switch_ff <= last_switch_in;
         armed_ff       <= armed_in;
         elapsed_ff     <= elapsed_in;
         flip_ff        <= flip_in;
      end
   end

   // relay is always off while the module is disabled
   `DLSC_ASSERT(a_off_when_disabled, clock, reset, !enabled_ff |-> !relay_on_ff)
   // invalid mode never reaches the mode register
   `DLSC_ASSERT(a_mode_valid, clock, reset, light_mode_ff != LM_INVALID)
   // notify only comes out of auto mode
   `DLSC_ASSERT(a_notify_auto, clock, reset,
      (fire && notify) |-> (light_mode_in == LM_AUTO && changed))
   // state holds when no item executes
   `DLSC_ASSERT(a_hold_idle, clock, reset,
      !fire |=> ($stable(light_mode_ff) && $stable(relay_on_ff) && $stable(flip_ff)))
   // a rejected command changes nothing
   `DLSC_ASSERT(a_reject_quiet, clock, reset, (fire && rejected) |-> !changed)

endmodule

/* sim/debounced_light_switch_control_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the debounced light switch control unit: directed and random events,
// with a behavioral predictor in a small scoreboard class. Depends on dlsc_pkg and the top level.
module debounced_light_switch_control_unit_tb;
   import dlsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either channel
   localparam int DRAIN_CYCLES   = 4;     // two-stage pipe plus margin

   // Predicts the status beat of every accepted event and holds the ones still to come.
   class light_switch_board;
      bit [7:0]             debounce_ms;
      bit                   on_level;
      bit                   en;
      bit [1:0]             lmode;
      bit                   relay;
      bit                   rec_light;
      bit                   last_sw;
      bit                   armed;
      bit [TIMER_WIDTH-1:0] elapsed;
      bit [1:0]             flips;
      result_type           expected_status[$];
      int                   errors;

      function new();
         debounce_ms = DEBOUNCE_RESET;
         on_level    = 1'b1;
         en          = 1'b1;
         lmode       = LM_AUTO;
         errors      = 0;
      endfunction

      function void configure(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_DEBOUNCE_TIME)
            debounce_ms = val;
         else if (idx == CSR_RELAY_ON_LEVEL)
            on_level = val[0];
      endfunction

      // back to auto: the relay state becomes the recorded light, and a switch
      // that disagrees with it is made to look like a fresh change
      function void resume_auto(bit sw);
         lmode     = LM_AUTO;
         rec_light = relay;
         if (sw != rec_light)
            last_sw = ~sw;
      endfunction

      function void record_event(item_type ev);
         result_type r;
         bit         sw;
         bit         notify;
         bit         changed;
         sw        = ev.switch_level;
         notify    = 1'b0;
         changed   = 1'b0;
         r         = '0;
         case (ev.mode)
            EV_TICK: begin
               // time runs on an armed counter even while disabled
               if (armed && elapsed != '1)
                  elapsed++;
               if (en) begin
                  if (flips >= FLIP_LIMIT) begin
                     resume_auto(sw);
                     changed = 1'b1;
                     flips   = '0;
                  end else if (lmode == LM_ON && !rec_light) begin
                     relay     = 1'b1;
                     rec_light = 1'b1;
                  end else if (lmode == LM_OFF && rec_light) begin
                     relay     = 1'b0;
                     rec_light = 1'b0;
                  end
                  if (last_sw != sw) begin
                     armed   = 1'b1;
                     elapsed = '0;
                     last_sw = sw;
                  end
                  if (armed && elapsed > debounce_ms) begin
                     armed = 1'b0;
                     if (sw != rec_light) begin
                        if (lmode != LM_AUTO) begin
                           if (flips != FLIP_MAX)
                              flips++;
                        end else begin
                           relay     = sw;
                           rec_light = sw;
                           notify    = 1'b1;
                           changed   = 1'b1;
                           flips     = '0;
                        end
                     end
                  end
               end
            end
            EV_SET_MODE: begin
               if (ev.new_light_mode == LM_INVALID)
                  r.rejected = 1'b1;
               else if (ev.new_light_mode != lmode) begin
                  if (ev.new_light_mode == LM_AUTO)
                     resume_auto(sw);
                  else begin
                     lmode     = ev.new_light_mode;
                     rec_light = relay;
                  end
                  changed = 1'b1;
               end
            end
            EV_ENABLE: begin
               if (!en) begin
                  relay   = (lmode == LM_AUTO) ? sw : (lmode == LM_ON);
                  en      = 1'b1;
                  changed = 1'b1;
               end
            end
            default: begin
               if (en) begin
                  relay   = 1'b0;
                  en      = 1'b0;
                  changed = 1'b1;
               end
            end
         endcase
         r.relay_pin      = relay ? on_level : ~on_level;
         r.notify         = notify;
         r.light_mode_now = lmode;
         r.module_enabled = en;
         r.state_changed  = changed;
         expected_status.push_back(r);
      endfunction

      function void compare_field(string name, logic [1:0] want, logic [1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_status(logic [7:0] beat);
         result_type want;
         if (expected_status.size() == 0) begin
            $display("%0t: status beat %h arrived with none outstanding", $time, beat);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         compare_field("relay_pin", {1'b0, want.relay_pin}, {1'b0, beat[0]});
         compare_field("notify", {1'b0, want.notify}, {1'b0, beat[1]});
         compare_field("rejected", {1'b0, want.rejected}, {1'b0, beat[2]});
         compare_field("light_mode_now", want.light_mode_now, beat[4:3]);
         compare_field("module_enabled", {1'b0, want.module_enabled}, {1'b0, beat[5]});
         compare_field("state_changed", {1'b0, want.state_changed}, {1'b0, beat[6]});
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [1:0] mode, [2] switch_level, [4:3] new_light_mode, [7:5] zero
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] relay_pin, [1] notify, [2] rejected, [4:3] light_mode_now,
   // [5] module_enabled, [6] state_changed, [7] zero
   logic [7:0]            rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   light_switch_board board = new();

   int tx_gap_max   = 0;     // upper bound of the random sender idle gap before each beat
   int rx_gap_max   = 0;     // upper bound of the random receiver stall after each beat
   int rx_hold      = 0;
   int quiet_cycles = 0;
   bit wall_level   = 1'b0;  // slowly moving wall switch for random ticks

   debounced_light_switch_control_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check every beat, then stall for a freshly drawn number of cycles.
   always @(posedge clock) begin : rx_side
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold    <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         board.check_status(rsp_tdata);
         stall = $urandom_range(0, rx_gap_max);
         rx_hold    <= stall;
         rsp_tready <= (stall == 0);
      end else if (rx_hold > 1) begin
         rx_hold <= rx_hold - 1;
      end else begin
         rx_hold    <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: too long without a beat on either channel means the block hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic item_type mk(logic [1:0] m, logic sw, logic [1:0] nm);
      item_type ev;
      ev.mode           = m;
      ev.switch_level   = sw;
      ev.new_light_mode = nm;
      return ev;
   endfunction

   // One event beat: optional idle gap, then hold valid until the block takes it.
   // Valid stays high across back-to-back beats so it is never lowered and raised in one step.
   task automatic send_event(item_type ev);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, ev.new_light_mode, ev.switch_level, ev.mode};
      do @(posedge clock); while (!req_tready);
      board.record_event(ev);
   endtask

   // Stop sending and wait for every outstanding status beat, then let the pipe settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.configure(idx, val);
   endtask

   // Only called with the block idle (after reset or after a drain).
   task automatic set_config(logic [7:0] dt, logic lvl);
      write_reg(CSR_DEBOUNCE_TIME, dt);
      write_reg(CSR_RELAY_ON_LEVEL, {7'b0, lvl});
      csr_we <= 1'b0;
   endtask

   // Mostly ticks with a switch level that holds for stretches around the debounce
   // time, so the debouncer really fires; mode, enable and disable events mixed in.
   task automatic run_random(int count);
      item_type ev;
      int       hold;
      int       pick;
      int       dt;
      hold = 0;
      dt   = int'(board.debounce_ms);
      for (int n = 0; n < count; n++) begin
         pick              = $urandom_range(0, 99);
         ev.new_light_mode = 2'($urandom_range(0, 3));
         ev.switch_level   = 1'($urandom_range(0, 1));
         if (pick < 78) begin
            ev.mode = EV_TICK;
            if (hold == 0) begin
               wall_level = ~wall_level;
               hold       = $urandom_range(1, dt + dt / 2 + 4);
            end
            hold--;
            ev.switch_level = wall_level;
         end else if (pick < 88)
            ev.mode = EV_SET_MODE;
         else if (pick < 94)
            ev.mode = EV_ENABLE;
         else
            ev.mode = EV_DISABLE;
         send_event(ev);
      end
   endtask

   initial begin
      item_type script[$];
      bit       sw;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero debounce so every stable change acts one tick after it is seen.
      set_config(8'd0, 1'b1);
      script = '{
         mk(EV_TICK, 1'b0, LM_AUTO),
         mk(EV_TICK, 1'b1, LM_INVALID),      // switch change arms the counter
         mk(EV_TICK, 1'b1, LM_AUTO),         // auto turns light on, notify
         mk(EV_SET_MODE, 1'b0, LM_INVALID),  // invalid mode rejected
         mk(EV_SET_MODE, 1'b1, LM_AUTO),     // same mode, no change
         mk(EV_SET_MODE, 1'b1, LM_OFF),
         mk(EV_TICK, 1'b1, LM_AUTO),         // forced off applied on tick
         mk(EV_TICK, 1'b0, LM_AUTO),
         mk(EV_TICK, 1'b0, LM_AUTO),
         mk(EV_TICK, 1'b1, LM_AUTO),
         mk(EV_TICK, 1'b1, LM_AUTO),         // first flip
         mk(EV_TICK, 1'b0, LM_AUTO),
         mk(EV_TICK, 1'b0, LM_AUTO),
         mk(EV_TICK, 1'b1, LM_AUTO),
         mk(EV_TICK, 1'b1, LM_AUTO),         // second flip
         mk(EV_TICK, 1'b1, LM_AUTO),         // two flips: back to auto
         mk(EV_SET_MODE, 1'b0, LM_ON),
         mk(EV_DISABLE, 1'b1, LM_OFF),
         mk(EV_DISABLE, 1'b0, LM_ON),        // already disabled
         mk(EV_TICK, 1'b0, LM_AUTO),         // tick while disabled
         mk(EV_SET_MODE, 1'b1, LM_AUTO),     // accepted while disabled
         mk(EV_ENABLE, 1'b1, LM_INVALID),    // auto relay follows the switch
         mk(EV_ENABLE, 1'b0, LM_AUTO),       // already enabled
         mk(EV_SET_MODE, 1'b0, LM_ON),
         mk(EV_TICK, 1'b0, LM_AUTO)          // forced on, relay already on
      };
      foreach (script[i])
         send_event(script[i]);
      drain();

      // Zero debounce, inverted relay polarity, heavy idling on both sides.
      set_config(8'd0, 1'b0);
      tx_gap_max = 7;
      rx_gap_max = 7;
      run_random(80);
      drain();

      // Short debounce; sender idles, receiver always ready. Pause mid-way for every result.
      set_config(8'd3, 1'b1);
      tx_gap_max = 7;
      rx_gap_max = 0;
      run_random(40);
      drain();
      run_random(40);
      drain();

      // Longest debounce: saturate the elapsed counter while disabled, then let it act.
      set_config(8'd255, 1'b0);
      tx_gap_max = 0;
      rx_gap_max = 7;
      send_event(mk(EV_ENABLE, 1'b0, LM_AUTO));
      sw = ~board.last_sw;
      send_event(mk(EV_TICK, sw, LM_AUTO));
      send_event(mk(EV_DISABLE, sw, LM_AUTO));
      repeat (520)
         send_event(mk(EV_TICK, sw, LM_AUTO));
      send_event(mk(EV_ENABLE, sw, LM_AUTO));
      send_event(mk(EV_TICK, sw, LM_AUTO));
      run_random(30);
      drain();

      // Back to the reset settings.
      set_config(DEBOUNCE_RESET, 1'b1);
      tx_gap_max = 7;
      rx_gap_max = 7;
      run_random(60);
      drain();

      if (board.errors == 0 && board.expected_status.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/dlsc_pkg.sv
design/dlsc_core.sv
design/debounced_light_switch_control_unit.sv
sim/debounced_light_switch_control_unit_tb.sv
